### rtl/core/jasc_pkg.sv
`default_nettype none

package jasc_pkg;

	// Item field widths
	localparam int CH_W         = 2;
	localparam int NUM_CHANNELS = 4;
	localparam int SAMPLE_BITS  = 16;
	localparam int AXIS_W       = 18;
	localparam int WEIGHT_W     = 7;
	localparam int OUT_RANGE_W  = 16;
	localparam int CALIB_W      = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = CALIB_W;

	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB0  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB1  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB2  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB3  = 3'd6;

	// Reset values
	localparam logic [WEIGHT_W-1:0]           PCT_FULL      = 7'd100;
	localparam logic signed [OUT_RANGE_W-1:0] OUT_MIN_RESET = -16'sd32767;
	localparam logic signed [OUT_RANGE_W-1:0] OUT_MAX_RESET = 16'sd32767;
	localparam logic [CALIB_W-1:0]            CALIB_RESET   = 48'hFFFF_7FFF_0000;
	localparam logic [SAMPLE_BITS-1:0]        SMOOTH_RESET  = 16'h7FFF;

	// Shared divider
	localparam int DIVIDEND_W = 32;
	localparam int DIVISOR_W  = 16;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// Mapping arithmetic
	localparam int SEG_W  = SAMPLE_BITS + 2;
	localparam int PROD_W = 35;
	localparam int ACC_W  = 23;
	localparam int RES_W  = 34;

	localparam logic signed [RES_W-1:0] AXIS_MAX_RES = 34'sd131071;
	localparam logic signed [RES_W-1:0] AXIS_MIN_RES = -34'sd131072;
	localparam logic [AXIS_W-1:0]       AXIS_MAX_VAL = 18'h1FFFF;
	localparam logic [AXIS_W-1:0]       AXIS_MIN_VAL = 18'h20000;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/jasc_div.sv
`default_nettype none

module jasc_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire jasc_pkg::div_req_t req,
	output jasc_pkg::div_rsp_t      rsp
);
	import jasc_pkg::*;

	localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIVIDEND_W - 1);

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W:0]    shifted;
	logic [DIVISOR_W:0]    trial;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		shifted = {rem_q, quo_q[DIVIDEND_W-1]};
		trial   = shifted - {1'b0, dvs_q};
	end

	// Count one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[DIVISOR_W]) begin
				rem_q <= trial[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DIVISOR_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> rsp.busy)
		else $error("divider did not go busy after start");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done)
		else $error("divider done held longer than one cycle");

	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp.busy) |-> rsp.done)
		else $error("divider left busy without done");

endmodule

`default_nettype wire

### rtl/core/joystick_axis_smooth_calibrate_core.sv
`default_nettype none

// Joystick axis smoothing and calibration. Each item on the slave stream is one
// ADC sample with its channel in tuser; each produces exactly one calibrated
// axis value on the master stream, in order. With a smoothing weight below 100
// an item takes two passes of one shared 32-step shift-subtract divider, each
// a start, one quotient bit per cycle and a done. The shared multiplier works
// before each divide and the segment select before the second; the result is
// then loaded into the output register and the next item is taken. With the
// weight at 100 or above smoothing is skipped. A zero-width calibration
// segment skips the second divide, so the result is ready in the cycle after
// the segment select. The block takes no new item until the current one has
// been handed to the output register, which holds one finished result while
// the next item is worked on; a stalled master stream holds the finished item
// in the block and so holds off the next one. Write configuration only while
// no item is in flight; writes are never held off.
module joystick_axis_smooth_calibrate_core (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	// Configuration write port
	input  wire logic                                    cfg_we,
	input  wire logic [jasc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [jasc_pkg::CFG_DATA_W-1:0]         cfg_data,
	// Sample stream
	input  wire logic                                    s_tvalid,
	output logic                                         s_tready,
	input  wire logic [jasc_pkg::SAMPLE_BITS-1:0]        s_tdata,  // [15:0] sample
	input  wire logic [jasc_pkg::CH_W-1:0]               s_tuser,  // [1:0] channel
	// Axis stream
	output logic                                         m_tvalid,
	input  wire logic                                    m_tready,
	output logic [23:0]                                  m_tdata,  // [17:0] axis_value
	output logic [2:0]                                   m_tuser   // [1:0] axis_channel, [2] calib_fault
);
	import jasc_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_MUL1  = 10'b00_0000_0010,
		ST_MUL2  = 10'b00_0000_0100,
		ST_DIV1  = 10'b00_0000_1000,
		ST_WAIT1 = 10'b00_0001_0000,
		ST_MAP   = 10'b00_0010_0000,
		ST_MUL3  = 10'b00_0100_0000,
		ST_DIV2  = 10'b00_1000_0000,
		ST_WAIT2 = 10'b01_0000_0000,
		ST_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [WEIGHT_W-1:0]           weight_q;
	logic signed [OUT_RANGE_W-1:0] out_min_q;
	logic signed [OUT_RANGE_W-1:0] out_max_q;
	logic [CALIB_W-1:0]            calib_q [NUM_CHANNELS];

	// Per-channel smoothing state
	logic [SAMPLE_BITS-1:0] smooth_q [NUM_CHANNELS];

	// Item in flight
	logic [CH_W-1:0]        ch_q;
	logic [SAMPLE_BITS-1:0] v_q;
	logic [SAMPLE_BITS-1:0] cmin_q;
	logic [SAMPLE_BITS-1:0] cmid_q;
	logic [SAMPLE_BITS-1:0] cmax_q;
	logic signed [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]       acc_q;
	logic signed [SEG_W-1:0] diff_q;
	logic signed [SEG_W-1:0] den_q;
	logic signed [SEG_W-1:0] base_q;
	logic                   sign_q;
	logic [AXIS_W-1:0]      res_q;
	logic                   fault_q;

	// Output register
	logic                   m_tvalid_q;
	logic [CH_W-1:0]        m_chan_q;
	logic [AXIS_W-1:0]      m_val_q;
	logic                   m_fault_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   bypass;

	logic signed [SEG_W-2:0]       span;
	logic signed [SEG_W-2:0]       span_adj;
	logic signed [OUT_RANGE_W-1:0] md;

	logic signed [SEG_W-1:0]   mul_a;
	logic signed [SEG_W-2:0]   mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic signed [SEG_W-1:0]   v_ext;
	logic signed [SEG_W-1:0]   cmin_ext;
	logic signed [SEG_W-1:0]   cmid_ext;
	logic signed [SEG_W-1:0]   cmax_ext;
	logic                      upper;
	logic signed [SEG_W-1:0]   seg_diff;
	logic signed [SEG_W-1:0]   seg_den;
	logic signed [SEG_W-1:0]   seg_base;

	logic signed [PROD_W-1:0]  num_mag;
	logic signed [SEG_W-1:0]   den_mag;
	logic signed [RES_W-1:0]   q_mag;
	logic signed [RES_W-1:0]   q_sgn;
	logic signed [RES_W-1:0]   res_full;
	logic [AXIS_W-1:0]         res_sat;

	div_req_t div_req;
	div_rsp_t div_rsp;

	assign in_accept = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign bypass    = (weight_q >= PCT_FULL);

	// Half of the output span, truncated toward zero
	always_comb begin
		span     = {out_max_q[OUT_RANGE_W-1], out_max_q} - {out_min_q[OUT_RANGE_W-1], out_min_q};
		span_adj = span + {{(SEG_W-2){1'b0}}, span[SEG_W-2]};
		md       = span_adj[SEG_W-2:1];
	end

	// Shared multiplier operand selection
	always_comb begin
		case (state_q)
			ST_MUL1: begin
				mul_a = {2'b00, v_q};
				mul_b = {{(SEG_W-1-WEIGHT_W){1'b0}}, weight_q};
			end
			ST_MUL2: begin
				mul_a = {2'b00, smooth_q[ch_q]};
				mul_b = {{(SEG_W-1-WEIGHT_W){1'b0}}, PCT_FULL - weight_q};
			end
			default: begin
				mul_a = diff_q;
				mul_b = {md[OUT_RANGE_W-1], md};
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// Pick the calibration segment
	always_comb begin
		v_ext    = {2'b00, v_q};
		cmin_ext = {2'b00, cmin_q};
		cmid_ext = {2'b00, cmid_q};
		cmax_ext = {2'b00, cmax_q};
		upper    = (v_q > cmid_q);
		if (upper) begin
			seg_diff = v_ext - cmid_ext;
			seg_den  = cmax_ext - cmid_ext;
			seg_base = {{2{out_min_q[OUT_RANGE_W-1]}}, out_min_q} +
			           {{2{md[OUT_RANGE_W-1]}}, md};
		end else begin
			seg_diff = v_ext - cmin_ext;
			seg_den  = cmid_ext - cmin_ext;
			seg_base = {{2{out_min_q[OUT_RANGE_W-1]}}, out_min_q};
		end
	end

	// Sign-magnitude operands for the mapping divide, and the final sum
	always_comb begin
		num_mag  = prod_q[PROD_W-1] ? -prod_q : prod_q;
		den_mag  = den_q[SEG_W-1] ? -den_q : den_q;
		q_mag    = {{(RES_W-DIVIDEND_W){1'b0}}, div_rsp.quotient};
		q_sgn    = sign_q ? -q_mag : q_mag;
		res_full = {{(RES_W-SEG_W){base_q[SEG_W-1]}}, base_q} + q_sgn;
		if (res_full > AXIS_MAX_RES) begin
			res_sat = AXIS_MAX_VAL;
		end else if (res_full < AXIS_MIN_RES) begin
			res_sat = AXIS_MIN_VAL;
		end else begin
			res_sat = res_full[AXIS_W-1:0];
		end
	end

	// Divider requests: smoothing by the percent base, then the segment divide
	always_comb begin
		div_req.start = (state_q == ST_DIV1) || (state_q == ST_DIV2);
		if (state_q == ST_DIV2) begin
			div_req.dividend = num_mag[DIVIDEND_W-1:0];
			div_req.divisor  = den_mag[DIVISOR_W-1:0];
		end else begin
			div_req.dividend = {{(DIVIDEND_W-ACC_W){1'b0}}, acc_q};
			div_req.divisor  = {{(DIVISOR_W-WEIGHT_W){1'b0}}, PCT_FULL};
		end
	end

	jasc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Configuration register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q  <= PCT_FULL;
			out_min_q <= OUT_MIN_RESET;
			out_max_q <= OUT_MAX_RESET;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				calib_q[i] <= CALIB_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WEIGHT:  weight_q   <= cfg_data[WEIGHT_W-1:0];
				REG_OUT_MIN: out_min_q  <= cfg_data[OUT_RANGE_W-1:0];
				REG_OUT_MAX: out_max_q  <= cfg_data[OUT_RANGE_W-1:0];
				REG_CALIB0:  calib_q[0] <= cfg_data;
				REG_CALIB1:  calib_q[1] <= cfg_data;
				REG_CALIB2:  calib_q[2] <= cfg_data;
				REG_CALIB3:  calib_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Store the smoothed value when the smoothing divide finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				smooth_q[i] <= SMOOTH_RESET;
			end
		end else if (state_q == ST_WAIT1 && div_rsp.done) begin
			smooth_q[ch_q] <= div_rsp.quotient[SAMPLE_BITS-1:0];
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (in_accept) state_q <= bypass ? ST_MAP : ST_MUL1;
				ST_MUL1:  state_q <= ST_MUL2;
				ST_MUL2:  state_q <= ST_DIV1;
				ST_DIV1:  state_q <= ST_WAIT1;
				ST_WAIT1: if (div_rsp.done) state_q <= ST_MAP;
				ST_MAP:   state_q <= (seg_den == '0) ? ST_OUT : ST_MUL3;
				ST_MUL3:  state_q <= ST_DIV2;
				ST_DIV2:  state_q <= ST_WAIT2;
				ST_WAIT2: if (div_rsp.done) state_q <= ST_OUT;
				ST_OUT:   if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// Item datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ch_q   <= s_tuser;
				v_q    <= s_tdata;
				cmin_q <= calib_q[s_tuser][15:0];
				cmid_q <= calib_q[s_tuser][31:16];
				cmax_q <= calib_q[s_tuser][47:32];
			end
			ST_MUL1: prod_q <= mul_p;
			ST_MUL2: acc_q  <= prod_q[ACC_W-1:0] + mul_p[ACC_W-1:0];
			ST_WAIT1: begin
				if (div_rsp.done) begin
					v_q <= div_rsp.quotient[SAMPLE_BITS-1:0];
				end
			end
			ST_MAP: begin
				diff_q <= seg_diff;
				den_q  <= seg_den;
				base_q <= seg_base;
				// Zero-width segment reports the low end and flags it
				res_q   <= {{(AXIS_W-OUT_RANGE_W){out_min_q[OUT_RANGE_W-1]}}, out_min_q};
				fault_q <= (seg_den == '0);
			end
			ST_MUL3: prod_q <= mul_p;
			ST_DIV2: sign_q <= prod_q[PROD_W-1] ^ den_q[SEG_W-1];
			ST_WAIT2: begin
				if (div_rsp.done) begin
					res_q <= res_sat;
				end
			end
			default: ;
		endcase
	end

	// Output register: load a finished item, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_chan_q  <= ch_q;
			m_val_q   <= res_q;
			m_fault_q <= fault_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(24-AXIS_W){1'b0}}, m_val_q};
	assign m_tuser  = {m_fault_q, m_chan_q};

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_rsp.busy)
		else $error("divider busy while no item is in flight");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_WAIT1 || state_q == ST_WAIT2))
		else $error("divider finished outside a wait state");

	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("output loaded without a finished item");

endmodule

`default_nettype wire
